// File: design/ttqc_pkg.sv
// Shared types, constants and helpers for the text tokenizer.
package ttqc_pkg;

  localparam int unsigned TOKEN_MAX   = 128;
  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned START_W     = 16;
  localparam int unsigned MAX_RES     = 3;
  localparam int unsigned Q_DEPTH     = 4;
  localparam int unsigned Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int unsigned Q_IDX_W     = $clog2(Q_DEPTH);
  localparam int unsigned N_W         = $clog2(MAX_RES + 1);

  localparam logic [LEN_W-1:0] LEN_MAX       = LEN_W'(TOKEN_MAX);
  localparam logic [LEN_W-1:0] LEN_QUOTE_MAX = LEN_W'(TOKEN_MAX - 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_END      = 2'd1,
    KIND_DISCARD  = 2'd2,
    KIND_TEXT_END = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_SLASH   = 5'b00010,
    MODE_COMMENT = 5'b00100,
    MODE_WORD    = 5'b01000,
    MODE_QUOTE   = 5'b10000
  } mode_e;

  typedef struct packed {
    kind_e               kind;
    logic [7:0]          ch;
    logic [START_W-1:0]  start;
    logic                last;
  } res_t;

  typedef struct packed {
    logic [N_W-1:0]        n;
    res_t [MAX_RES-1:0]    res;
  } push_t;

  function automatic logic [START_W-1:0] start_bits(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+START_W-1:0] ext;
    ext = {{START_W{1'b0}}, v};
    return ext[START_W-1:0];
  endfunction

  function automatic res_t mk_res(input kind_e kind, input logic [7:0] ch,
                                  input logic [OFFSET_BITS-1:0] start);
    res_t r;
    r.kind  = kind;
    r.ch    = (kind == KIND_BYTE) ? ch : 8'h00;
    r.start = (kind == KIND_TEXT_END) ? '0 : start_bits(start);
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

// File: design/ttqc_scan.sv
// Scanner state and per-word result generation.
module ttqc_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           text_byte_i,
  input  logic                 hib_i,
  output ttqc_pkg::push_t      push_o
);

  ttqc_pkg::mode_e                      mode_q, mode_d;
  logic [ttqc_pkg::LEN_W-1:0]           len_q, len_d;
  logic [ttqc_pkg::OFFSET_BITS-1:0]     offset_q, offset_d;
  logic [ttqc_pkg::OFFSET_BITS-1:0]     start_q, start_d;

  always_comb begin
    logic [ttqc_pkg::OFFSET_BITS-1:0] here;
    logic [ttqc_pkg::OFFSET_BITS-1:0] inc;
    logic                             blank;
    logic                             do_word;
    logic [ttqc_pkg::LEN_W-1:0]       wlen;
    logic [ttqc_pkg::N_W-1:0]         n;
    ttqc_pkg::res_t [ttqc_pkg::MAX_RES-1:0] res;

    here     = offset_q;
    inc      = (here == '1) ? here : here + 1'b1;
    blank    = (text_byte_i <= ttqc_pkg::CH_SPACE) || (hib_i && text_byte_i[7]);
    do_word  = 1'b0;
    wlen     = len_q;
    n        = '0;
    res      = '0;
    mode_d   = mode_q;
    len_d    = len_q;
    start_d  = start_q;

    unique case (mode_q)
      ttqc_pkg::MODE_SLASH: begin
        if (text_byte_i == ttqc_pkg::CH_SLASH) begin
          mode_d = ttqc_pkg::MODE_COMMENT;
        end else begin
          res[n]  = ttqc_pkg::mk_res(ttqc_pkg::KIND_BYTE, ttqc_pkg::CH_SLASH, start_q);
          n       = n + 1'b1;
          wlen    = ttqc_pkg::LEN_W'(1);
          mode_d  = ttqc_pkg::MODE_WORD;
          do_word = 1'b1;
        end
      end
      ttqc_pkg::MODE_COMMENT: begin
        if (text_byte_i == ttqc_pkg::CH_NUL) begin
          mode_d = ttqc_pkg::MODE_IDLE;
          res[n] = ttqc_pkg::mk_res(ttqc_pkg::KIND_TEXT_END, 8'h00, '0);
          n      = n + 1'b1;
        end else if (text_byte_i == ttqc_pkg::CH_NL) begin
          mode_d = ttqc_pkg::MODE_IDLE;
        end
      end
      ttqc_pkg::MODE_WORD: begin
        do_word = 1'b1;
      end
      ttqc_pkg::MODE_QUOTE: begin
        if (text_byte_i == ttqc_pkg::CH_QUOTE || text_byte_i == ttqc_pkg::CH_NUL) begin
          res[n] = ttqc_pkg::mk_res(ttqc_pkg::KIND_END, 8'h00, start_q);
          n      = n + 1'b1;
          len_d  = '0;
          mode_d = ttqc_pkg::MODE_IDLE;
          if (text_byte_i == ttqc_pkg::CH_NUL) begin
            res[n] = ttqc_pkg::mk_res(ttqc_pkg::KIND_TEXT_END, 8'h00, '0);
            n      = n + 1'b1;
          end
        end else if (len_q < ttqc_pkg::LEN_QUOTE_MAX) begin
          res[n] = ttqc_pkg::mk_res(ttqc_pkg::KIND_BYTE, text_byte_i, start_q);
          n      = n + 1'b1;
          len_d  = len_q + 1'b1;
        end
      end
      default: begin
        mode_d = ttqc_pkg::MODE_IDLE;
        len_d  = '0;
        if (text_byte_i == ttqc_pkg::CH_NUL) begin
          res[n] = ttqc_pkg::mk_res(ttqc_pkg::KIND_TEXT_END, 8'h00, '0);
          n      = n + 1'b1;
        end else if (blank) begin
          // skip blank between tokens
        end else if (text_byte_i == ttqc_pkg::CH_SLASH) begin
          start_d = here;
          mode_d  = ttqc_pkg::MODE_SLASH;
        end else if (text_byte_i == ttqc_pkg::CH_QUOTE) begin
          start_d = inc;
          mode_d  = ttqc_pkg::MODE_QUOTE;
        end else begin
          start_d = here;
          res[n]  = ttqc_pkg::mk_res(ttqc_pkg::KIND_BYTE, text_byte_i, here);
          n       = n + 1'b1;
          len_d   = ttqc_pkg::LEN_W'(1);
          mode_d  = ttqc_pkg::MODE_WORD;
        end
      end
    endcase

    if (do_word) begin
      if (text_byte_i != ttqc_pkg::CH_NUL && !blank) begin
        len_d = wlen;
        if (wlen < ttqc_pkg::LEN_MAX) begin
          res[n] = ttqc_pkg::mk_res(ttqc_pkg::KIND_BYTE, text_byte_i, start_q);
          n      = n + 1'b1;
          len_d  = wlen + 1'b1;
        end
      end else begin
        res[n] = ttqc_pkg::mk_res((wlen >= ttqc_pkg::LEN_MAX) ? ttqc_pkg::KIND_DISCARD
                                                              : ttqc_pkg::KIND_END,
                                  8'h00, start_q);
        n      = n + 1'b1;
        len_d  = '0;
        mode_d = ttqc_pkg::MODE_IDLE;
        if (text_byte_i == ttqc_pkg::CH_NUL) begin
          res[n] = ttqc_pkg::mk_res(ttqc_pkg::KIND_TEXT_END, 8'h00, '0);
          n      = n + 1'b1;
        end
      end
    end

    if (n != '0) begin
      res[n - 1'b1].last = 1'b1;
    end

    offset_d   = (text_byte_i == ttqc_pkg::CH_NUL) ? '0 : inc;
    push_o.n   = accept_i ? n : '0;
    push_o.res = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ttqc_pkg::MODE_IDLE;
      len_q    <= '0;
      offset_q <= '0;
      start_q  <= '0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      len_q    <= len_d;
      offset_q <= offset_d;
      start_q  <= start_d;
    end
  end

endmodule

// File: design/ttqc_rsq.sv
// Result queue: takes up to three results a cycle, hands out one.
module ttqc_rsq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ttqc_pkg::push_t     push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ttqc_pkg::res_t      head_o
);

  ttqc_pkg::res_t                  ent_q [ttqc_pkg::Q_DEPTH];
  ttqc_pkg::res_t                  ent_d [ttqc_pkg::Q_DEPTH];
  logic [ttqc_pkg::Q_CNT_W-1:0]    count_q, count_d;
  logic                            pop;

  assign out_valid_o = (count_q != '0);
  assign head_o      = ent_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (count_q <= ttqc_pkg::Q_CNT_W'(ttqc_pkg::Q_DEPTH - ttqc_pkg::MAX_RES));

  always_comb begin
    logic [ttqc_pkg::Q_CNT_W-1:0] base;
    logic [ttqc_pkg::Q_CNT_W-1:0] pos;

    for (int i = 0; i < ttqc_pkg::Q_DEPTH - 1; i++) begin
      if (pop) begin
        ent_d[i] = ent_q[i + 1];
      end else begin
        ent_d[i] = ent_q[i];
      end
    end
    ent_d[ttqc_pkg::Q_DEPTH - 1] = ent_q[ttqc_pkg::Q_DEPTH - 1];
    base = count_q - ttqc_pkg::Q_CNT_W'(pop);
    for (int k = 0; k < ttqc_pkg::MAX_RES; k++) begin
      pos = base + ttqc_pkg::Q_CNT_W'(k);
      if (ttqc_pkg::N_W'(k) < push_i.n) begin
        ent_d[pos[ttqc_pkg::Q_IDX_W-1:0]] = push_i.res[k];
      end
    end
    count_d = base + ttqc_pkg::Q_CNT_W'(push_i.n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ttqc_pkg::Q_DEPTH; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

endmodule

// File: design/text_tokenizer_quotes_comments_top.sv
// Top level of the streaming text tokenizer with quoted tokens and line comments.
//
// Input channel: in_valid_i / in_ready_o carry one text byte per word; byte 0
// ends the current text. Output channel: out_valid_o / out_ready_i carry one
// result per word (kind, token character, start offset, last flag); an input
// byte gives zero to three results, the final one marked by last_o.
// cfg_we_i writes cfg_wdata_i into the high-bytes-are-blank flag; write only
// while the block is idle.
// A result is registered into the result queue when its byte is accepted.
// Throughput: one byte a cycle while each byte gives at most one result; the
// output side drains one result a cycle while out_ready_i is high, through a
// four-entry result queue, and input is taken while it holds at most one result.
// Reset: scanner between tokens, offsets and length cleared, queue empty,
// high bytes treated as blanks.
// Receiver stall: results hold in the queue; once it holds two or more,
// in_ready_o drops until the receiver takes results again.
module text_tokenizer_quotes_comments_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  token_char_o,
  output logic [15:0] start_offset_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  logic                hib_q;
  logic                accept;
  ttqc_pkg::push_t     push;
  ttqc_pkg::res_t      head;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hib_q <= 1'b1;
    end else if (cfg_we_i) begin
      hib_q <= cfg_wdata_i;
    end
  end

  ttqc_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (text_byte_i),
    .hib_i       (hib_q),
    .push_o      (push)
  );

  ttqc_rsq u_rsq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign kind_o         = head.kind;
  assign token_char_o   = head.ch;
  assign start_offset_o = head.start;
  assign last_o         = head.last;

endmodule
